FILE: hdl/desa_pkg.sv
// Shared types and constants for the directory entry slot allocator.
package desa_pkg;

   localparam int BLOCK_WORDS = 1024;
   localparam int ADDR_W      = $clog2(BLOCK_WORDS);
   localparam int CSR_W       = 13;
   localparam int OFF_W       = 14;
   localparam int WORD_W      = OFF_W - 2;
   localparam int NEED_W      = 9;
   localparam int HDR_BYTES   = 8;
   localparam logic [31:0] LIMIT_MAX  = 32'(BLOCK_WORDS * 4);
   localparam logic [CSR_W-1:0] BLOCK_BYTES_RESET = CSR_W'(1024);

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_ALLOC = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
   localparam logic [1:0] STATUS_CORRUPT = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [9:0]  word_index;
      logic [31:0] word_data;
      logic [7:0]  name_bytes;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status;
      logic [11:0] entry_offset;
   } rsp_type;

endpackage

FILE: hdl/desa_ram.sv
// Generic single-port RAM with registered read data.
module desa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/dir_entry_slot_allocator.sv
// Directory block store with a sequenced entry slot allocator.
//
// Usage: a request is taken on a rising edge where start is high and busy is
// low. req_data.cmd selects a word write, a word read or an allocation of a
// directory entry slot for req_data.name_bytes bytes of name. Every request,
// including the unused command code, gives exactly one response: rsp_valid is
// high for one cycle with rsp_data, and the receiver must take it then.
// Sequencing: a write does not make the block busy, so the next request may
// follow at once; its response appears the cycle after it is taken. A read
// holds busy in S_RDOUT while the single RAM port returns data, and its
// response is registered from that state. An allocation visits records in
// turn through the one RAM port: two header reads (S_RDI, S_RDW) and an
// evaluation step (S_EVAL) per record, then up to three header writes. An
// oversized request is answered without a walk, the cycle after it is taken.
// The block size register is written on csr_valid (csr_ready is always high)
// and should only change while no request is in flight.
// Reset returns the sequencer to idle, drops any pending response and sets the
// block size to 1024 bytes. The word store is not cleared and holds undefined
// data until software writes it.
module dir_entry_slot_allocator
   import desa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_RDOUT = 8'b0000_0010,
      S_RDI   = 8'b0000_0100,
      S_RDW   = 8'b0000_1000,
      S_EVAL  = 8'b0001_0000,
      S_WR0   = 8'b0010_0000,
      S_WR1   = 8'b0100_0000,
      S_WR2   = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [CSR_W-1:0]  block_bytes_ff;
   logic [7:0]        nl_ff, nl_in;
   logic [NEED_W-1:0] needed_ff, needed_in;
   logic [OFF_W-1:0]  limit_ff, limit_in;
   logic [OFF_W-1:0]  bound_ff, bound_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [OFF_W-1:0]  nx_ff, nx_in;
   logic [11:0]       pos_ff, pos_in;
   logic [31:0]       new_hdr_ff, new_hdr_in;
   logic [31:0]       old_hdr_ff, old_hdr_in;
   logic              inode_nz_ff, inode_nz_in;
   logic              rd_oob_ff, rd_oob_in;

   logic              accept;
   logic [CSR_W-1:0]  lim_raw;
   logic [31:0]       lim_full;
   logic [31:0]       hdr_nl;
   logic              too_big;

   logic [WORD_W-1:0] ram_word;
   logic              ram_oob;
   logic              ram_we_c;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [31:0]       ram_wdata_c;
   logic [31:0]       ram_rdata;

   logic [31:0]       w1;
   logic [15:0]       es;
   logic [OFF_W-1:0]  lim_off;
   logic              corrupt;
   logic [NEED_W-1:0] own;
   logic              used_fit;
   logic              free_fit;
   logic [15:0]       rem_used;
   logic [15:0]       rem_free;
   logic              free_split;
   logic [16:0]       next_off;
   logic              more;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // Block limit: size rounded down to whole words and clamped to the store.
   assign lim_raw  = {block_bytes_ff[CSR_W-1:2], 2'b00};
   assign lim_full = (32'(lim_raw) > LIMIT_MAX) ? LIMIT_MAX : 32'(lim_raw);
   assign hdr_nl   = 32'(req_data.name_bytes) + 32'(HDR_BYTES);
   assign too_big  = hdr_nl > lim_full;

   // Header fields of the record under examination.
   assign w1         = rd_oob_ff ? 32'd0 : ram_rdata;
   assign es         = w1[15:0];
   assign lim_off    = limit_ff - off_ff;
   assign corrupt    = (es == 16'd0) || (es[1:0] != 2'b00) || (17'(es) > 17'(lim_off));
   assign own        = (NEED_W'(w1[23:16]) + NEED_W'(HDR_BYTES + 3)) & ~NEED_W'(3);
   assign used_fit   = (17'(own) + 17'(needed_ff)) <= 17'(es);
   assign free_fit   = 17'(es) >= 17'(needed_ff);
   assign rem_used   = es - 16'(own);
   assign rem_free   = es - 16'(needed_ff);
   assign free_split = rem_free >= 16'(HDR_BYTES);
   assign next_off   = 17'(off_ff) + 17'(es);
   assign more       = next_off < 17'(bound_ff);

   // RAM port address and write selection.
   always_comb begin
      ram_word    = off_ff[OFF_W-1:2];
      ram_wdata_c = 32'd0;
      ram_we_c    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            ram_word    = WORD_W'(req_data.word_index);
            ram_wdata_c = req_data.word_data;
            ram_we_c    = accept && (req_data.cmd == CMD_WRITE);
         end
         S_RDI: begin
            ram_word = off_ff[OFF_W-1:2];
         end
         S_RDW: begin
            ram_word = off_ff[OFF_W-1:2] + WORD_W'(1);
         end
         S_WR0: begin
            ram_word    = nx_ff[OFF_W-1:2];
            ram_wdata_c = 32'd0;
            ram_we_c    = 1'b1;
         end
         S_WR1: begin
            ram_word    = nx_ff[OFF_W-1:2] + WORD_W'(1);
            ram_wdata_c = new_hdr_ff;
            ram_we_c    = 1'b1;
         end
         S_WR2: begin
            ram_word    = off_ff[OFF_W-1:2] + WORD_W'(1);
            ram_wdata_c = old_hdr_ff;
            ram_we_c    = 1'b1;
         end
         default: begin
            ram_word = off_ff[OFF_W-1:2];
         end
      endcase
   end

   // Words past the end of the store read as zero and ignore writes.
   assign ram_oob  = 32'(ram_word) >= 32'(BLOCK_WORDS);
   assign ram_we   = ram_we_c && !ram_oob;
   assign ram_addr = ADDR_W'(ram_word);

   desa_ram #(
      .WIDTH (32),
      .DEPTH (BLOCK_WORDS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata_c),
      .rdata (ram_rdata)
   );

   always_comb begin
      logic advance;
      advance      = 1'b0;
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      nl_in        = nl_ff;
      needed_in    = needed_ff;
      limit_in     = limit_ff;
      bound_in     = bound_ff;
      off_in       = off_ff;
      nx_in        = nx_ff;
      pos_in       = pos_ff;
      new_hdr_in   = new_hdr_ff;
      old_hdr_in   = old_hdr_ff;
      inode_nz_in  = inode_nz_ff;
      rd_oob_in    = ram_oob;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_WRITE: begin
                     rsp_valid_in = 1'b1;
                  end
                  CMD_READ: begin
                     state_in = S_RDOUT;
                  end
                  CMD_ALLOC: begin
                     if (too_big) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_NO_ROOM;
                     end else begin
                        nl_in     = req_data.name_bytes;
                        needed_in = NEED_W'((hdr_nl + 32'd3) & ~32'd3);
                        limit_in  = OFF_W'(lim_full);
                        bound_in  = OFF_W'(lim_full - hdr_nl);
                        off_in    = '0;
                        state_in  = S_RDI;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_RDOUT: begin
            rsp_valid_in     = 1'b1;
            rsp_in.read_data = rd_oob_ff ? 32'd0 : ram_rdata;
            state_in         = S_IDLE;
         end
         S_RDI: begin
            state_in = S_RDW;
         end
         S_RDW: begin
            inode_nz_in = !rd_oob_ff && (ram_rdata != 32'd0);
            state_in    = S_EVAL;
         end
         S_EVAL: begin
            if (corrupt) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_CORRUPT;
               state_in      = S_IDLE;
            end else if (inode_nz_ff) begin
               if (used_fit) begin
                  // Used record with slack: a new free header follows its own part.
                  nx_in      = off_ff + OFF_W'(own);
                  pos_in     = 12'(off_ff + OFF_W'(own));
                  new_hdr_in = {8'h00, nl_ff, rem_used};
                  old_hdr_in = {w1[31:16], 16'(own)};
                  state_in   = S_WR0;
               end else begin
                  advance = 1'b1;
               end
            end else if (free_fit) begin
               // Free record is taken, and split when a header's worth is left.
               nx_in      = off_ff + OFF_W'(needed_ff);
               pos_in     = 12'(off_ff);
               new_hdr_in = {16'h0000, rem_free};
               old_hdr_in = {w1[31:24], nl_ff, free_split ? 16'(needed_ff) : w1[15:0]};
               state_in   = free_split ? S_WR0 : S_WR2;
            end else begin
               advance = 1'b1;
            end
            if (advance) begin
               if (more) begin
                  off_in   = OFF_W'(next_off);
                  state_in = S_RDI;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = STATUS_NO_ROOM;
                  state_in      = S_IDLE;
               end
            end
         end
         S_WR0: begin
            state_in = S_WR1;
         end
         S_WR1: begin
            state_in = S_WR2;
         end
         S_WR2: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = STATUS_OK;
            rsp_in.entry_offset = pos_ff;
            state_in            = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         block_bytes_ff <= BLOCK_BYTES_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            block_bytes_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      nl_ff       <= nl_in;
      needed_ff   <= needed_in;
      limit_ff    <= limit_in;
      bound_ff    <= bound_in;
      off_ff      <= off_in;
      nx_ff       <= nx_in;
      pos_ff      <= pos_in;
      new_hdr_ff  <= new_hdr_in;
      old_hdr_ff  <= old_hdr_in;
      inode_nz_ff <= inode_nz_in;
      rd_oob_ff   <= rd_oob_in;
   end

   // An accepted write is answered in the very next cycle.
   a_write_rsp : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.cmd == CMD_WRITE)) |=> rsp_valid)
      else $error("write request not answered in the next cycle");

   // A read waiting on RAM data is answered once the data returns.
   a_read_rsp : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RDOUT) |=> (rsp_valid && (rsp_data.status == STATUS_OK)))
      else $error("read response missing");

   // Allocated entries always start on a word boundary.
   a_offset_align : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_OK)) |-> (rsp_data.entry_offset[1:0] == 2'b00))
      else $error("entry offset not word aligned");

   // The store is written only on a write request or in a header update step.
   a_write_source : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == S_IDLE) || (state_ff == S_WR0) || (state_ff == S_WR1)
                  || (state_ff == S_WR2)))
      else $error("store written outside a write step");

endmodule

FILE: tb/slot_alloc_monitor.sv
// Watches the allocator's channels, predicts each response and compares it.
`timescale 1ns / 100ps

module slot_alloc_monitor
   import desa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  rsp_type          rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data,
   output int               mismatches,
   output int               rsp_due
);

   localparam logic [31:0] HDR = 32'(HDR_BYTES);

   logic [31:0]      dir_words [BLOCK_WORDS];
   logic [CSR_W-1:0] blk_bytes;
   rsp_type          rsp_due_q [$];

   // The stimulus never reads a word before writing it, so the start value is arbitrary.
   initial begin
      for (int i = 0; i < BLOCK_WORDS; i++) dir_words[i] = '0;
   end

   function automatic logic [31:0] round4(input logic [31:0] v);
      return (v + 32'd3) & ~32'd3;
   endfunction

   function automatic logic [31:0] word_at(input logic [31:0] byte_off);
      return ((byte_off >> 2) < BLOCK_WORDS) ? dir_words[byte_off >> 2] : '0;
   endfunction

   function automatic void put_word(input logic [31:0] byte_off, input logic [31:0] v);
      if ((byte_off >> 2) < BLOCK_WORDS) dir_words[byte_off >> 2] = v;
   endfunction

   // Walks the records from offset 0 and places an entry for nl name bytes.
   function automatic logic [1:0] place_entry(input logic [7:0] nl, output logic [11:0] slot);
      logic [31:0] lim, need, stop, pos, node, hdr, rec, own, nx, upd;
      slot = '0;
      lim = 32'(blk_bytes) & ~32'd3;
      if (lim > LIMIT_MAX) lim = LIMIT_MAX;
      if (HDR + 32'(nl) > lim) return STATUS_NO_ROOM;
      need = round4(HDR + 32'(nl));
      stop = lim - 32'(nl) - HDR;
      pos  = '0;
      do begin
         node = word_at(pos);
         hdr  = word_at(pos + 32'd4);
         rec  = hdr & 32'h0000_FFFF;
         if (rec == 0 || rec[1:0] != 2'b00 || rec > lim - pos) return STATUS_CORRUPT;
         if (node != 0) begin
            own = round4(HDR + 32'(hdr[23:16]));
            if (own + need <= rec) begin
               nx = pos + own;
               put_word(nx, '0);
               put_word(nx + 32'd4, ((rec - own) & 32'h0000_FFFF) | (32'(nl) << 16));
               put_word(pos + 32'd4, (hdr & 32'hFFFF_0000) | own);
               slot = nx[11:0];
               return STATUS_OK;
            end
         end else if (rec >= need) begin
            upd = hdr;
            // Split the free record only when a whole header fits in what is left.
            if (rec - need >= HDR) begin
               nx = pos + need;
               put_word(nx, '0);
               put_word(nx + 32'd4, (rec - need) & 32'h0000_FFFF);
               upd = (upd & 32'hFFFF_0000) | need;
            end
            upd = (upd & 32'hFF00_FFFF) | (32'(nl) << 16);
            put_word(pos + 32'd4, upd);
            slot = pos[11:0];
            return STATUS_OK;
         end
         pos = pos + rec;
      end while (pos < stop);
      return STATUS_NO_ROOM;
   endfunction

   function automatic rsp_type serve_request(input req_type r);
      rsp_type     res;
      logic [11:0] slot;
      res = '0;
      case (r.cmd)
         CMD_WRITE: begin
            if (r.word_index < BLOCK_WORDS) dir_words[r.word_index] = r.word_data;
         end
         CMD_READ: begin
            if (r.word_index < BLOCK_WORDS) res.read_data = dir_words[r.word_index];
         end
         CMD_ALLOC: begin
            res.status       = place_entry(r.name_bytes, slot);
            res.entry_offset = slot;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic flag(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: response %s mismatch, got %h, predicted %h", $realtime, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         blk_bytes  = BLOCK_BYTES_RESET;
         mismatches = 0;
         rsp_due_q.delete();
      end else begin
         if (csr_valid && csr_ready) blk_bytes = csr_data;
         // A response always belongs to a request taken at an earlier edge.
         if (rsp_valid) begin
            if (rsp_due_q.size() == 0) begin
               flag("without request", 32'(rsp_data.status), '0);
            end else begin
               want = rsp_due_q.pop_front();
               if (rsp_data.read_data !== want.read_data)
                  flag("read_data", rsp_data.read_data, want.read_data);
               if (rsp_data.status !== want.status)
                  flag("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.entry_offset !== want.entry_offset)
                  flag("entry_offset", 32'(rsp_data.entry_offset), 32'(want.entry_offset));
            end
         end
         if (start && !busy) rsp_due_q.insert(rsp_due_q.size(), serve_request(req_data));
      end
      rsp_due <= rsp_due_q.size();
   end

endmodule

FILE: tb/tb_top.sv
// Stimulus and verdict for the directory entry slot allocator.
`timescale 1ns / 100ps

module tb_top;
   import desa_pkg::*;

   localparam logic [1:0] CMD_SPARE = 2'd3;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_data;
   int               mismatches;
   int               rsp_due;

   int unsigned      blk_limit;
   int               burst_left;
   int               requests_sent;
   bit               filled [BLOCK_WORDS];

   dir_entry_slot_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   slot_alloc_monitor i_monitor (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .rsp_due    (rsp_due)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic req_type rand_req(input logic [1:0] op);
      req_type r;
      r.cmd        = op;
      r.word_index = ADDR_W'($urandom);
      r.word_data  = $urandom;
      r.name_bytes = 8'($urandom);
      return r;
   endfunction

   // The sender runs in bursts; a gap follows each burst.
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 30);
      end
   endtask

   task automatic issue(input req_type r);
      start    <= 1'b1;
      req_data <= r;
      if (r.cmd == CMD_WRITE) filled[r.word_index] = 1'b1;
      requests_sent++;
      do @(posedge clock); while (busy);
      pace();
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (rsp_due != 0);
   endtask

   task automatic write_word(input int unsigned idx, input logic [31:0] data);
      req_type r;
      r = rand_req(CMD_WRITE);
      r.word_index = ADDR_W'(idx);
      r.word_data  = data;
      issue(r);
   endtask

   task automatic read_word(input int unsigned idx);
      req_type r;
      r = rand_req(CMD_READ);
      r.word_index = ADDR_W'(idx);
      issue(r);
   endtask

   task automatic alloc_entry(input logic [7:0] nl);
      req_type r;
      r = rand_req(CMD_ALLOC);
      r.name_bytes = nl;
      issue(r);
   endtask

   // The block size only changes once every request has been answered.
   task automatic set_block_bytes(input logic [CSR_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      blk_limit = 32'(v) & ~32'd3;
      if (blk_limit > LIMIT_MAX) blk_limit = LIMIT_MAX;
   endtask

   function automatic logic [CSR_W-1:0] pick_block_bytes();
      case ($urandom_range(0, 9))
         0:       return CSR_W'(64);
         1:       return CSR_W'(4096);
         2:       return '1;
         3:       return CSR_W'($urandom_range(0, 63));
         4:       return CSR_W'($urandom) | CSR_W'(1);
         default: return CSR_W'($urandom_range(64, 4096));
      endcase
   endfunction

   // Lays out a chain of records over the whole block, now and then with a
   // damaged record size that ends the chain.
   task automatic build_layout();
      int unsigned pos, room, rec, nl;
      logic [31:0] node, hdr;
      pos = 0;
      while (pos + 8 <= blk_limit) begin
         room = blk_limit - pos;
         rec  = $urandom_range(8, (room > 400) ? 400 : room) & ~32'd3;
         if (room - rec < 8 || $urandom_range(0, 7) == 0) rec = room;
         node = ($urandom_range(0, 2) == 0) ? 32'd0 : ($urandom | 32'd1);
         nl   = (node != 0) ? $urandom_range(0, (rec - 8 > 255) ? 255 : rec - 8)
                            : $urandom_range(0, 255);
         hdr  = {8'($urandom), 8'(nl), 16'(rec)};
         if ($urandom_range(0, 29) == 0) begin
            case ($urandom_range(0, 2))
               0:       hdr[15:0] = 16'(rec | 2);
               1:       hdr[15:0] = '0;
               default: hdr[15:0] = 16'(room + 4);
            endcase
            write_word(pos >> 2, node);
            write_word((pos >> 2) + 1, hdr);
            break;
         end
         write_word(pos >> 2, node);
         write_word((pos >> 2) + 1, hdr);
         pos += rec;
      end
   endtask

   task automatic random_request();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         r = rand_req(CMD_ALLOC);
         if ($urandom_range(0, 3) != 0) r.name_bytes = 8'($urandom_range(0, 40));
      end else if (pick < 82) begin
         r = rand_req(CMD_READ);
         // Reads only go to words the stimulus has already written.
         if (!filled[r.word_index]) r.word_index = '0;
      end else if (pick < 94) begin
         r = rand_req(CMD_WRITE);
         // With bit 0 set, a record size hit by this write makes the walk stop as
         // corrupt rather than lead it to a word that was never written.
         r.word_data[0] = 1'b1;
      end else begin
         r = rand_req(CMD_SPARE);
      end
      issue(r);
   endtask

   initial begin
      req_type     spare;
      int          rounds;
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      blk_limit     = 32'(BLOCK_BYTES_RESET);
      burst_left    = 0;
      requests_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // The first record header is written before any walk reads it.
      write_word(0, '0);
      write_word(1, '0);

      spare = '1;
      spare.cmd = CMD_SPARE;
      issue(spare);
      alloc_entry(8'd0);                    // zero record size
      write_word(1, 32'h0000_0006);
      alloc_entry(8'd3);                    // size not a multiple of four
      write_word(1, 32'h0000_0404);
      alloc_entry(8'd0);                    // record reaches past the end
      write_word(1, 32'hAB00_0400);
      alloc_entry(8'd255);                  // free record taken and split
      write_word(0, 32'd1);
      alloc_entry(8'd0);
      alloc_entry(8'd255);
      write_word(1023, '1);
      read_word(1);
      read_word(1023);
      write_word(0, 32'd2);
      write_word(1, 32'h5A00_0400);
      alloc_entry(8'd255);                  // slack of a used record split off
      write_word(0, 32'd0);
      write_word(1, 32'h0000_000C);
      alloc_entry(8'd1);                    // exact fit, no split
      alloc_entry(8'd4);

      set_block_bytes(CSR_W'(64));
      write_word(0, 32'd1);
      write_word(1, {8'h00, 8'd40, 16'd64});
      alloc_entry(8'd12);                   // walk runs out of block
      alloc_entry(8'd255);                  // request larger than the block
      set_block_bytes('1);                  // clamped to the store
      alloc_entry(8'd7);
      set_block_bytes(CSR_W'(4095));        // low bits ignored

      rounds = 0;
      while (requests_sent < 500) begin
         if (rounds % 2 == 1) set_block_bytes(pick_block_bytes());
         build_layout();
         repeat ($urandom_range(16, 32)) begin
            random_request();
         end
         rounds++;
      end

      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
